[rtl/ssfl_pkg.sv]
// ----------------------------------------------------------------------------
// ssfl_pkg
// shared types and constants of the segregated sorted free list
// ----------------------------------------------------------------------------
package ssfl_pkg;

  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned ENTRY_W     = SIZE_W + HANDLE_W;
  localparam int unsigned ITEM_BASE_W = 1 + SIZE_W + HANDLE_W;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_HIT   = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

endpackage

[rtl/ssfl_if.sv]
// ----------------------------------------------------------------------------
// ssfl_if
// request and response channels of the segregated sorted free list
// ----------------------------------------------------------------------------
interface ssfl_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] block_size;
  logic [15:0] block_handle;

  modport source (output valid, kind, block_size, block_handle, input ready);
  modport sink   (input valid, kind, block_size, block_handle, output ready);
endinterface

interface ssfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_handle;

  modport source (output valid, status, found_handle, input ready);
  modport sink   (input valid, status, found_handle, output ready);
endinterface

[rtl/segregated_sorted_free_list.sv]
// ----------------------------------------------------------------------------
// segregated_sorted_free_list
// per-thread cache of freed blocks, bucketed by size and kept sorted
// ----------------------------------------------------------------------------
// in_i takes one request word per valid/ready handshake: kind 0 adds a freed
// block (size, handle), kind 1 takes a block of exactly the given size.
// out_o returns one word per request, in order: status and found handle.
// The front computes the bucket (size mod NUM_BUCKETS) behind its register
// from a reciprocal multiply before it; a two-entry queue feeds the engine.
// The engine first reads the bucket row on the row ram port, then searches,
// shifts and writes the row back; it takes no new request before the last
// is done. An accepted request passes the front register, the queue, the
// engine's item register and row read, and then the result register.
// Reset clears all bucket fill counts at once through per-row valid bits;
// no clearing pass, so requests are taken as soon as reset is released.
// When out_o stalls the result register holds, the engine waits, and the
// queue and front keep taking requests until they are full.
// ----------------------------------------------------------------------------
module segregated_sorted_free_list #(
  parameter int unsigned NUM_BUCKETS  = 16,
  parameter int unsigned BUCKET_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssfl_req_if.sink    in_i,
  ssfl_rsp_if.source  out_o
);
  import ssfl_pkg::*;

  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned ITEM_W = ITEM_BASE_W + BKT_W;

  logic              fr_valid, fr_ready;
  logic [ITEM_W-1:0] fr_item;
  logic              q_valid, q_pop;
  logic [ITEM_W-1:0] q_item;

  ssfl_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (in_i),
    .push_valid_o (fr_valid),
    .push_item_o  (fr_item),
    .push_ready_i (fr_ready)
  );

  ssfl_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_item)
  );

  ssfl_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .rsp_o     (out_o)
  );

endmodule

[rtl/ssfl_ram.sv]
// ----------------------------------------------------------------------------
// ssfl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ssfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/ssfl_front.sv]
// ----------------------------------------------------------------------------
// ssfl_front
// accepts request words and classifies them into a bucket (size mod count)
// ----------------------------------------------------------------------------
module ssfl_front #(
  parameter int unsigned NUM_BUCKETS = 16,
  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int unsigned ITEM_W = ssfl_pkg::ITEM_BASE_W + BKT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssfl_req_if.sink          req_i,
  output logic              push_valid_o,
  output logic [ITEM_W-1:0] push_item_o,
  input  logic              push_ready_i
);
  import ssfl_pkg::*;

  localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W  = SIZE_W + RECIP_W;
  localparam int unsigned REM_W   = SIZE_W + 1;
  localparam int unsigned QN_W    = SIZE_W + 8;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / NUM_BUCKETS);

  logic                s1_valid_q, s1_valid_d;
  logic                s1_kind_q;
  logic [SIZE_W-1:0]   s1_size_q;
  logic [HANDLE_W-1:0] s1_handle_q;
  logic [SIZE_W-1:0]   s1_quot_q;

  logic [PROD_W-1:0]   prod;
  logic [QN_W-1:0]     quot_n;
  logic [REM_W-1:0]    rem_raw;
  logic [REM_W-1:0]    rem_fix;
  logic                accept;

  assign req_i.ready = !s1_valid_q || push_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // reciprocal estimate, low by at most one
  assign prod = PROD_W'(req_i.block_size) * PROD_W'(RECIP);

  assign quot_n  = QN_W'(s1_quot_q) * QN_W'(NUM_BUCKETS);
  assign rem_raw = REM_W'(s1_size_q) - quot_n[REM_W-1:0];
  assign rem_fix = (rem_raw >= REM_W'(NUM_BUCKETS)) ? rem_raw - REM_W'(NUM_BUCKETS)
                                                     : rem_raw;

  assign push_valid_o = s1_valid_q;
  assign push_item_o  = {s1_kind_q, s1_size_q, s1_handle_q, rem_fix[BKT_W-1:0]};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= req_i.kind;
      s1_size_q   <= req_i.block_size;
      s1_handle_q <= req_i.block_handle;
      s1_quot_q   <= prod[RECIP_SHIFT +: SIZE_W];
    end
  end

endmodule

[rtl/ssfl_queue.sv]
// ----------------------------------------------------------------------------
// ssfl_queue
// two-entry queue between the classifier and the bucket engine
// ----------------------------------------------------------------------------
module ssfl_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/ssfl_back.sv]
// ----------------------------------------------------------------------------
// ssfl_back
// bucket engine: reads one bucket row, inserts or removes, writes it back
// ----------------------------------------------------------------------------
module ssfl_back #(
  parameter int unsigned NUM_BUCKETS  = 16,
  parameter int unsigned BUCKET_DEPTH = 8,
  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int unsigned ITEM_W = ssfl_pkg::ITEM_BASE_W + BKT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [ITEM_W-1:0] q_item_i,
  output logic              q_pop_o,
  ssfl_rsp_if.source        rsp_o
);
  import ssfl_pkg::*;

  localparam int unsigned FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned ENTS_W  = BUCKET_DEPTH * ENTRY_W;
  localparam int unsigned ROW_W   = ENTS_W + FILL_W;

  back_state_e          state_q, state_d;
  logic                 item_kind_q;
  logic [SIZE_W-1:0]    item_size_q;
  logic [HANDLE_W-1:0]  item_handle_q;
  logic [BKT_W-1:0]     item_bkt_q;
  logic [NUM_BUCKETS-1:0] row_vld_q;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [HANDLE_W-1:0]  hdl_q, hdl_d;
  logic                 load_out;

  logic                 ram_re, ram_we;
  logic [ROW_W-1:0]     rdata, wdata;

  logic [FILL_W-1:0]    fill;
  logic [ENTRY_W-1:0]   ent     [BUCKET_DEPTH];
  logic [ENTRY_W-1:0]   ent_up  [BUCKET_DEPTH];
  logic [ENTRY_W-1:0]   ent_dn  [BUCKET_DEPTH];
  logic [BUCKET_DEPTH-1:0] lt;
  logic [FILL_W-1:0]    pos;
  logic                 hit;
  logic [HANDLE_W-1:0]  hit_hdl;
  logic [ROW_W-1:0]     add_row, take_row;
  logic                 start;

  ssfl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_bkt_q),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (q_item_i[BKT_W-1:0]),
    .rdata_o (rdata)
  );

  // row decode and search
  always_comb begin
    fill    = row_vld_q[item_bkt_q] ? rdata[ENTS_W +: FILL_W] : '0;
    pos     = FILL_W'(BUCKET_DEPTH);
    hit     = 1'b0;
    hit_hdl = '0;
    for (int k = 0; k < BUCKET_DEPTH; k++) begin
      ent[k] = rdata[k*ENTRY_W +: ENTRY_W];
    end
    for (int k = 0; k < BUCKET_DEPTH; k++) begin
      ent_up[k] = ent[k];
      ent_dn[k] = ent[k];
    end
    for (int k = 1; k < BUCKET_DEPTH; k++) begin
      ent_up[k] = ent[k-1];
    end
    for (int k = 0; k + 1 < BUCKET_DEPTH; k++) begin
      ent_dn[k] = ent[k+1];
    end
    for (int k = 0; k < BUCKET_DEPTH; k++) begin
      lt[k] = (FILL_W'(k) < fill) && (ent[k][SIZE_W-1:0] < item_size_q);
    end
    for (int k = BUCKET_DEPTH - 1; k >= 0; k--) begin
      if (!lt[k]) begin
        pos = FILL_W'(k);
      end
    end
    for (int k = 0; k < BUCKET_DEPTH; k++) begin
      if ((FILL_W'(k) == pos) && (FILL_W'(k) < fill) &&
          (ent[k][SIZE_W-1:0] == item_size_q)) begin
        hit     = 1'b1;
        hit_hdl = ent[k][SIZE_W +: HANDLE_W];
      end
    end
    add_row  = rdata;
    take_row = rdata;
    add_row[ENTS_W +: FILL_W]  = fill + FILL_W'(1);
    take_row[ENTS_W +: FILL_W] = fill - FILL_W'(1);
    for (int k = 0; k < BUCKET_DEPTH; k++) begin
      if (FILL_W'(k) == pos) begin
        add_row[k*ENTRY_W +: ENTRY_W] = {item_handle_q, item_size_q};
      end else if (FILL_W'(k) > pos) begin
        add_row[k*ENTRY_W +: ENTRY_W] = ent_up[k];
      end
      if (FILL_W'(k) >= pos) begin
        take_row[k*ENTRY_W +: ENTRY_W] = ent_dn[k];
      end
    end
  end

  assign start = q_valid_i && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    wdata    = add_row;
    load_out = 1'b0;
    status_d = ST_MISS;
    hdl_d    = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          q_pop_o = 1'b1;
          ram_re  = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        load_out = 1'b1;
        state_d  = BK_IDLE;
        if (item_kind_q == KIND_ADD) begin
          if (fill == FILL_W'(BUCKET_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_ADDED;
            ram_we   = 1'b1;
            wdata    = add_row;
          end
        end else if (hit) begin
          status_d = ST_HIT;
          hdl_d    = hit_hdl;
          ram_we   = 1'b1;
          wdata    = take_row;
        end else begin
          status_d = ST_MISS;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.found_handle = hdl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        row_vld_q[item_bkt_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_kind_q   <= q_item_i[ITEM_W-1];
      item_size_q   <= q_item_i[BKT_W + HANDLE_W +: SIZE_W];
      item_handle_q <= q_item_i[BKT_W +: HANDLE_W];
      item_bkt_q    <= q_item_i[BKT_W-1:0];
    end
    if (load_out) begin
      status_q <= status_d;
      hdl_q    <= hdl_d;
    end
  end

`ifndef SYNTHESIS
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EXEC |-> !out_valid_q)
    else $error("result register busy while a row is executed");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_EXEC |=> state_q == BK_IDLE)
    else $error("row execution lasted more than one cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> wdata[ENTS_W +: FILL_W] <= FILL_W'(BUCKET_DEPTH))
    else $error("bucket fill written beyond depth");

  a_take_hit_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && status_d == ST_HIT |-> ram_we && fill != '0)
    else $error("take hit without row write back");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segregated sorted free list: a directed table
// of adds and takes, then random phases that vary bucket spread, add/take mix
// and idling on both channels, results checked against table or predictor
// ----------------------------------------------------------------------------
module tb_top;
  import ssfl_pkg::*;

  localparam int unsigned NUM_BUCKETS  = 16;
  localparam int unsigned BUCKET_DEPTH = 8;
  localparam int unsigned WDOG_LIMIT   = 2000;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned NUM_DIR      = 22;

  localparam int unsigned PH_FOCUS [NUM_PHASES] = '{16, 2, 4, 1, 16, 8};
  localparam int unsigned PH_ADD   [NUM_PHASES] = '{50, 60, 45, 65, 45, 50};
  localparam int unsigned PH_IDLE  [NUM_PHASES] = '{0, 30, 10, 60, 20, 0};

  typedef struct packed {
    status_e     status;
    logic [15:0] handle;
  } free_result_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] size;
    logic [15:0] handle;
    logic        typed;
    status_e     status;
    logic [15:0] found;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{KIND_TAKE, 16'h0001, 16'h0000, 1'b1, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h0000, 16'hffff, 1'b1, ST_MISS,  16'h0000},
    '{KIND_ADD,  16'h0000, 16'hffff, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_TAKE, 16'h0000, 16'h1234, 1'b1, ST_HIT,   16'hffff},
    '{KIND_ADD,  16'hffff, 16'h0001, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'hffff, 16'h0002, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h000f, 16'h0000, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h7fff, 16'haaaa, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h800f, 16'h5555, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h00ff, 16'h8000, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h0fff, 16'h7fff, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h1f0f, 16'h0f0f, 1'b1, ST_ADDED, 16'h0000},
    '{KIND_ADD,  16'h2f0f, 16'h1111, 1'b1, ST_FULL,  16'h0000},
    '{KIND_TAKE, 16'hffff, 16'h0000, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'hffff, 16'hffff, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h0eff, 16'h0000, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h1f0f, 16'hffff, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h000f, 16'h0000, 1'b0, ST_MISS,  16'h0000},
    '{KIND_ADD,  16'h2f0f, 16'h1111, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h8000, 16'h0000, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'h7fff, 16'h0000, 1'b0, ST_MISS,  16'h0000},
    '{KIND_TAKE, 16'hfff0, 16'h0000, 1'b0, ST_MISS,  16'h0000}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ssfl_req_if req_if ();
  ssfl_rsp_if rsp_if ();

  segregated_sorted_free_list #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_DEPTH(BUCKET_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the cache
  logic [15:0]  cache_size   [NUM_BUCKETS][BUCKET_DEPTH];
  logic [15:0]  cache_handle [NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned  bucket_cnt   [NUM_BUCKETS];

  free_result_t want_q [$];
  int unsigned  err_cnt     = 0;
  int unsigned  idle_pct    = 0;
  int unsigned  focus       = 16;
  int unsigned  rsp_stall   = 0;
  int unsigned  idle_cycles = 0;

  function automatic free_result_t cache_lookup(input logic kind, input logic [15:0] sz,
                                                input logic [15:0] hd);
    free_result_t r;
    int unsigned  b;
    int unsigned  n;
    int unsigned  p;
    int unsigned  i;
    b = sz % NUM_BUCKETS;
    n = bucket_cnt[b];
    p = 0;
    r.status = ST_ADDED;
    r.handle = '0;
    while (p < n && cache_size[b][p] < sz) p++;
    if (kind == KIND_ADD) begin
      if (n >= BUCKET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (i = n; i > p; i--) begin
          cache_size[b][i]   = cache_size[b][i-1];
          cache_handle[b][i] = cache_handle[b][i-1];
        end
        cache_size[b][p]   = sz;
        cache_handle[b][p] = hd;
        bucket_cnt[b]      = n + 1;
      end
    end else if (p >= n || cache_size[b][p] != sz) begin
      r.status = ST_MISS;
    end else begin
      r.status = ST_HIT;
      r.handle = cache_handle[b][p];
      for (i = p; i + 1 < n; i++) begin
        cache_size[b][i]   = cache_size[b][i+1];
        cache_handle[b][i] = cache_handle[b][i+1];
      end
      bucket_cnt[b] = n - 1;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_size();
    logic [15:0] s;
    if ($urandom_range(0, 99) < 25) begin
      s = 16'($urandom);
    end else begin
      s = (16'($urandom_range(0, 15)) << 4) | 16'($urandom_range(0, focus - 1));
    end
    return s;
  endfunction

  task automatic send_word(input logic k, input logic [15:0] s, input logic [15:0] h,
                           output free_result_t pred);
    req_if.valid        <= 1'b1;
    req_if.kind         <= k;
    req_if.block_size   <= s;
    req_if.block_handle <= h;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = cache_lookup(k, s, h);
  endtask

  task automatic idle_input(input int unsigned n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // result side: random stalls and in-order checking
  always @(posedge clk_i) begin
    free_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected word: status %0d, found_handle %h", rsp_if.status,
               rsp_if.found_handle);
        err_cnt++;
      end else begin
        want = want_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          err_cnt++;
        end
        if (rsp_if.found_handle !== want.handle) begin
          $error("found_handle: expected %h, actual %h", want.handle, rsp_if.found_handle);
          err_cnt++;
        end
      end
    end
    if (rsp_stall > 0) begin
      rsp_stall--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      rsp_stall = pick_gap();
    end
    rsp_if.ready <= (rsp_stall == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    free_result_t pred;
    logic         k;
    logic [15:0]  s;
    int unsigned  b;
    int unsigned  n;
    int unsigned  gap;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_ADD;
    req_if.block_size   = '0;
    req_if.block_handle = '0;
    foreach (bucket_cnt[i]) bucket_cnt[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      send_word(DIR_ROWS[i].kind, DIR_ROWS[i].size, DIR_ROWS[i].handle, pred);
      if (DIR_ROWS[i].typed) begin
        pred.status = DIR_ROWS[i].status;
        pred.handle = DIR_ROWS[i].found;
      end
      want_q.push_back(pred);
    end
    idle_input(1);
    while (want_q.size() != 0) @(posedge clk_i);

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      focus    = PH_FOCUS[ph];
      idle_pct = PH_IDLE[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < PH_ADD[ph]) begin
          k = KIND_ADD;
          s = pick_size();
        end else begin
          k = KIND_TAKE;
          b = $urandom_range(0, focus - 1);
          n = bucket_cnt[b];
          if (n > 0 && $urandom_range(0, 99) < 75) begin
            s = cache_size[b][$urandom_range(0, n - 1)];
          end else begin
            s = pick_size();
          end
        end
        send_word(k, s, 16'($urandom), pred);
        want_q.push_back(pred);
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        if (i == PHASE_ITEMS - 1) gap = gap + 1;
        idle_input(gap);
      end
      // drain the pipe before a dense phase
      if (ph == 2) begin
        while (want_q.size() != 0) @(posedge clk_i);
      end
    end

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
